// ----- rtl/core/fenwick_pair_moment_engine_defines.svh -----
// Assertion macros shared by the fenwick pair moment engine RTL.
// Expects signals named clock and reset in the scope of each use.
`ifndef FENWICK_PAIR_MOMENT_ENGINE_DEFINES_SVH
`define FENWICK_PAIR_MOMENT_ENGINE_DEFINES_SVH

// same-cycle implication
`define FPME_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FPME_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/fpme_pkg.sv -----
// Package for the fenwick pair moment engine: widths, codes, node row type
// and the micro-op program of the shared multiply-accumulate unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpme_pkg;

   localparam int RANK_W = 11;
   localparam int POS_W  = 16;
   localparam int VAL_W  = 32;
   localparam int CNT_W  = 32;
   localparam int SUM_W  = 64;
   localparam int HALF_W = 32;

   localparam int FPME_RANK_COUNT = 1024;
   localparam logic [RANK_W-1:0] RANKS_RESET = 11'd1024;

   // request actions
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // one tree node: four moments
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] sum_x;
      logic [SUM_W-1:0] sum_y;
      logic [SUM_W-1:0] sum_xy;
   } row_type;

   // operand sources of the multiplier
   localparam int SRC_W = 3;
   localparam logic [SRC_W-1:0] SRC_X  = 3'd0;
   localparam logic [SRC_W-1:0] SRC_Y  = 3'd1;
   localparam logic [SRC_W-1:0] SRC_XY = 3'd2;
   localparam logic [SRC_W-1:0] SRC_C  = 3'd3;
   localparam logic [SRC_W-1:0] SRC_SX = 3'd4;
   localparam logic [SRC_W-1:0] SRC_SY = 3'd5;

   typedef struct packed {
      logic valid;
      logic shift;    // product lands in the upper half
      logic negate;   // subtract instead of add
      logic to_xy;    // destination is the x*y register
      logic init;     // start from the initial value, not the running one
   } mac_ctl_type;

   typedef struct packed {
      logic [SRC_W-1:0] a_src;
      logic             a_hi;
      logic [SRC_W-1:0] b_src;
      logic             b_hi;
      logic             shift;
      logic             negate;
      logic             to_xy;
      logic             init;
   } mac_op_type;

   localparam int PROG_LEN = 10;
   localparam int OP_W     = $clog2(PROG_LEN);
   localparam logic [OP_W-1:0] OP_XY_FIRST  = OP_W'(0);
   localparam logic [OP_W-1:0] OP_XY_LAST   = OP_W'(1);
   localparam logic [OP_W-1:0] OP_MAC_FIRST = OP_W'(2);
   localparam logic [OP_W-1:0] OP_MAC_LAST  = OP_W'(PROG_LEN - 1);

   // 64-bit wrapped products from 32x32 partial products; the C*XY terms
   // come last so that x*y has settled before it is read
   function automatic mac_op_type mac_program(input logic [OP_W-1:0] idx);
      mac_op_type op;
      op = '0;
      case (idx)
         OP_W'(0): op = '{SRC_X,  1'b0, SRC_Y,  1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
         OP_W'(1): op = '{SRC_X,  1'b0, SRC_Y,  1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
         OP_W'(2): op = '{SRC_SX, 1'b0, SRC_Y,  1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
         OP_W'(3): op = '{SRC_SX, 1'b0, SRC_Y,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
         OP_W'(4): op = '{SRC_SX, 1'b1, SRC_Y,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
         OP_W'(5): op = '{SRC_SY, 1'b0, SRC_X,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
         OP_W'(6): op = '{SRC_SY, 1'b1, SRC_X,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
         OP_W'(7): op = '{SRC_C,  1'b0, SRC_XY, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
         OP_W'(8): op = '{SRC_C,  1'b0, SRC_XY, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
         OP_W'(9): op = '{SRC_C,  1'b1, SRC_XY, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
         default:  op = '0;
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fpme_node_ram.sv -----
// Node store of the fenwick pair moment engine: one row of four moments per node.
// Single write port, single registered read port. Depends on fpme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpme_node_ram
   import fpme_pkg::*;
#(
   parameter int DEPTH  = FPME_RANK_COUNT + 1,
   parameter int ADDR_W = $clog2(FPME_RANK_COUNT + 1)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  row_type           wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output row_type           rd_data_ff
);

   row_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/fpme_mac.sv -----
// Shared multiply-accumulate unit: a registered 32x32 multiply, then a 64-bit
// add or subtract into the x*y or the moment accumulator. Depends on fpme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpme_mac
   import fpme_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mac_ctl_type       ctl,
   input  logic [HALF_W-1:0] opnd_a,
   input  logic [HALF_W-1:0] opnd_b,
   input  logic [SUM_W-1:0]  init_value,
   output logic [SUM_W-1:0]  xy,
   output logic [SUM_W-1:0]  acc
);

   mac_ctl_type      ctl_ff;
   logic [SUM_W-1:0] prod_ff;
   logic [SUM_W-1:0] xy_ff, xy_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0] addend;
   logic [SUM_W-1:0] base;
   logic [SUM_W-1:0] total;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= opnd_a * opnd_b;
      xy_ff   <= xy_in;
      acc_ff  <= acc_in;
   end

   always_comb begin
      addend = ctl_ff.shift ? {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}} : prod_ff;
      if (ctl_ff.init) begin
         base = ctl_ff.to_xy ? '0 : init_value;
      end else begin
         base = ctl_ff.to_xy ? xy_ff : acc_ff;
      end
      total  = ctl_ff.negate ? base - addend : base + addend;
      xy_in  = xy_ff;
      acc_in = acc_ff;
      if (ctl_ff.valid) begin
         if (ctl_ff.to_xy) begin
            xy_in = total;
         end else begin
            acc_in = total;
         end
      end
   end

   assign xy  = xy_ff;
   assign acc = acc_ff;

endmodule

`default_nettype wire

// ----- rtl/core/fenwick_pair_moment_engine.sv -----
// Fenwick pair moment engine: walks a binary indexed tree of four moments per rank.
// Update: two MAC passes form x*y, then each path node is read, updated and written back.
// Query: two MAC passes form x*y, the RAM gives one node per cycle, eight MAC passes
// finish, and the result is registered for the response.
// One request at a time; ready only while idle, a finished result may wait meanwhile.
// Reset (synchronous, active high) starts a clearing pass that zeroes nodes 0 to RANK_COUNT.
`timescale 1ns / 1ps
`default_nettype none
`include "fenwick_pair_moment_engine_defines.svh"

module fenwick_pair_moment_engine
   import fpme_pkg::*;
#(
   parameter int RANK_COUNT = FPME_RANK_COUNT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_action,
   input  logic [RANK_W-1:0]        req_rank,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [VAL_W-1:0]  req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [SUM_W-1:0]  rsp_moment_sum,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [RANK_W-1:0]        csr_ranks_in_use
);

   localparam int NODE_W = $clog2(RANK_COUNT + 1);
   localparam int CMP_W  = (NODE_W > RANK_W) ? NODE_W : RANK_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_XY    = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_MAC   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;
   localparam logic [2:0] ST_PUSH  = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [RANK_W-1:0] ranks_ff, ranks_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic              go_ff, go_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [1:0]        action_ff, action_in;
   logic [POS_W-1:0]  x_ff, x_in;
   logic [VAL_W-1:0]  y_ff, y_in;
   logic [NODE_W-1:0] p_ff, p_in;
   logic [NODE_W-1:0] bound_ff, bound_in;
   logic [NODE_W-1:0] pend_addr_ff, pend_addr_in;
   logic [SUM_W-1:0]  c_sum_ff, c_sum_in;
   logic [SUM_W-1:0]  sx_sum_ff, sx_sum_in;
   logic [SUM_W-1:0]  sy_sum_ff, sy_sum_in;
   logic [SUM_W-1:0]  sxy_sum_ff, sxy_sum_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;

   logic              ram_wr_en;
   logic [NODE_W-1:0] ram_wr_addr;
   row_type           ram_wr_data;
   logic              ram_rd_en;
   logic [NODE_W-1:0] ram_rd_addr;
   row_type           ram_rd_data;
   row_type           upd_row;

   mac_op_type        cur_op;
   mac_ctl_type       mac_ctl;
   logic [SUM_W-1:0]  mac_xy;
   logic [SUM_W-1:0]  mac_acc;
   logic [SUM_W-1:0]  a_full, b_full;
   logic [HALF_W-1:0] a_word, b_word;

   logic [SUM_W-1:0]  x64, y64;
   logic [CMP_W-1:0]  rank_ext, cfg_ext, cap_ext, bound_c, q_start;
   logic              upd_go;
   logic [NODE_W-1:0] p_low;
   logic [NODE_W:0]   u_next;
   logic [NODE_W-1:0] q_next;
   logic              is_query;

   fpme_node_ram #(
      .DEPTH  (RANK_COUNT + 1),
      .ADDR_W (NODE_W)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_rd_data)
   );

   fpme_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mac_ctl),
      .opnd_a     (a_word),
      .opnd_b     (b_word),
      .init_value (sxy_sum_ff),
      .xy         (mac_xy),
      .acc        (mac_acc)
   );

   assign is_query = (action_ff == ACT_QUERY);
   assign x64 = {{(SUM_W - POS_W){1'b0}}, x_ff};
   assign y64 = {{(SUM_W - VAL_W){y_ff[VAL_W-1]}}, y_ff};

   // start and bound of the walk, decided on acceptance
   assign rank_ext = CMP_W'(req_rank);
   assign cfg_ext  = CMP_W'(ranks_ff);
   assign cap_ext  = CMP_W'(RANK_COUNT);
   assign bound_c  = (cfg_ext < cap_ext) ? cfg_ext : cap_ext;
   assign upd_go   = (rank_ext != '0) && (rank_ext <= bound_c);
   assign q_start  = (rank_ext > cap_ext) ? cap_ext : rank_ext;

   // next node: up by the lowest set bit for updates, down for queries
   assign p_low  = p_ff & (~p_ff + NODE_W'(1));
   assign u_next = {1'b0, p_ff} + {1'b0, p_low};
   assign q_next = p_ff & (p_ff - NODE_W'(1));

   always_comb begin
      upd_row = ram_rd_data;
      if (action_ff == ACT_REMOVE) begin
         upd_row.count  = ram_rd_data.count - CNT_W'(1);
         upd_row.sum_x  = ram_rd_data.sum_x - x64;
         upd_row.sum_y  = ram_rd_data.sum_y - y64;
         upd_row.sum_xy = ram_rd_data.sum_xy - mac_xy;
      end else begin
         upd_row.count  = ram_rd_data.count + CNT_W'(1);
         upd_row.sum_x  = ram_rd_data.sum_x + x64;
         upd_row.sum_y  = ram_rd_data.sum_y + y64;
         upd_row.sum_xy = ram_rd_data.sum_xy + mac_xy;
      end
   end

   // operand selection for the shared multiplier
   assign cur_op = mac_program(op_ff);

   always_comb begin
      case (cur_op.a_src)
         SRC_X:   a_full = x64;
         SRC_Y:   a_full = y64;
         SRC_XY:  a_full = mac_xy;
         SRC_C:   a_full = c_sum_ff;
         SRC_SX:  a_full = sx_sum_ff;
         SRC_SY:  a_full = sy_sum_ff;
         default: a_full = '0;
      endcase
      case (cur_op.b_src)
         SRC_X:   b_full = x64;
         SRC_Y:   b_full = y64;
         SRC_XY:  b_full = mac_xy;
         SRC_C:   b_full = c_sum_ff;
         SRC_SX:  b_full = sx_sum_ff;
         SRC_SY:  b_full = sy_sum_ff;
         default: b_full = '0;
      endcase
   end

   assign a_word = cur_op.a_hi ? a_full[SUM_W-1:HALF_W] : a_full[HALF_W-1:0];
   assign b_word = cur_op.b_hi ? b_full[SUM_W-1:HALF_W] : b_full[HALF_W-1:0];

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ranks_in     = ranks_ff;
      op_in        = op_ff;
      go_in        = go_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      action_in    = action_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      p_in         = p_ff;
      bound_in     = bound_ff;
      pend_addr_in = p_ff;
      c_sum_in     = c_sum_ff;
      sx_sum_in    = sx_sum_ff;
      sy_sum_in    = sy_sum_ff;
      sxy_sum_in   = sxy_sum_ff;
      rsp_sum_in   = rsp_sum_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pend_addr_ff;
      ram_wr_data  = upd_row;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = p_ff;
      mac_ctl      = '0;

      if (csr_valid) begin
         ranks_in = csr_ranks_in_use;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // node read last cycle: write back the updated row, or fold it into the sums
      if (pend_ff) begin
         if (is_query) begin
            c_sum_in   = c_sum_ff + {{(SUM_W - CNT_W){ram_rd_data.count[CNT_W-1]}},
                                     ram_rd_data.count};
            sx_sum_in  = sx_sum_ff + ram_rd_data.sum_x;
            sy_sum_in  = sy_sum_ff + ram_rd_data.sum_y;
            sxy_sum_in = sxy_sum_ff + ram_rd_data.sum_xy;
         end else begin
            ram_wr_en = 1'b1;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(RANK_COUNT)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               action_in  = req_action;
               x_in       = req_position;
               y_in       = req_value;
               bound_in   = bound_c[NODE_W-1:0];
               op_in      = OP_XY_FIRST;
               c_sum_in   = '0;
               sx_sum_in  = '0;
               sy_sum_in  = '0;
               sxy_sum_in = '0;
               if (req_action == ACT_QUERY) begin
                  p_in  = q_start[NODE_W-1:0];
                  go_in = (q_start != '0);
               end else begin
                  p_in  = rank_ext[NODE_W-1:0];
                  go_in = upd_go;
               end
               if (req_action != ACT_UNUSED) begin
                  state_in = ST_XY;
               end
            end
         end
         ST_XY: begin
            mac_ctl = '{1'b1, cur_op.shift, cur_op.negate, cur_op.to_xy, cur_op.init};
            op_in   = op_ff + OP_W'(1);
            if (op_ff == OP_XY_LAST) begin
               op_in = OP_MAC_FIRST;
               if (go_ff) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = is_query ? ST_MAC : ST_IDLE;
               end
            end
         end
         ST_WALK: begin
            ram_rd_en    = 1'b1;
            pend_in      = 1'b1;
            pend_addr_in = p_ff;
            if (is_query) begin
               if (q_next != '0) begin
                  p_in = q_next;
               end else begin
                  state_in = ST_DRAIN;
               end
            end else begin
               if (u_next <= {1'b0, bound_ff}) begin
                  p_in = u_next[NODE_W-1:0];
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = is_query ? ST_MAC : ST_IDLE;
         end
         ST_MAC: begin
            mac_ctl = '{1'b1, cur_op.shift, cur_op.negate, cur_op.to_xy, cur_op.init};
            op_in   = op_ff + OP_W'(1);
            if (op_ff == OP_MAC_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = mac_acc;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ranks_ff     <= RANKS_RESET;
         op_ff        <= OP_XY_FIRST;
         go_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ranks_ff     <= ranks_in;
         op_ff        <= op_in;
         go_ff        <= go_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      p_ff         <= p_in;
      bound_ff     <= bound_in;
      pend_addr_ff <= pend_addr_in;
      c_sum_ff     <= c_sum_in;
      sx_sum_ff    <= sx_sum_in;
      sy_sum_ff    <= sy_sum_in;
      sxy_sum_ff   <= sxy_sum_in;
      rsp_sum_ff   <= rsp_sum_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_moment_sum = rsp_sum_ff;

   `FPME_ASSERT_HOLDS(a_rw_apart, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr,
      "read and write hit the same node")
   `FPME_ASSERT_HOLDS(a_rd_range, ram_rd_en,
      ram_rd_addr != '0 && ram_rd_addr <= NODE_W'(RANK_COUNT), "node read out of range")
   `FPME_ASSERT_HOLDS(a_upd_rises, pend_ff && ram_rd_en && !is_query,
      ram_rd_addr > pend_addr_ff, "update walk not ascending")
   `FPME_ASSERT_HOLDS(a_qry_falls, pend_ff && ram_rd_en && is_query,
      ram_rd_addr < pend_addr_ff, "query walk not descending")
   `FPME_ASSERT_NEXT(a_push_hold, state_ff == ST_PUSH && rsp_valid_ff && !rsp_ready,
      state_ff == ST_PUSH && rsp_sum_ff == $past(rsp_sum_ff), "pending result overwritten")
   `FPME_ASSERT_HOLDS(a_rsp_src, $rose(rsp_valid_ff), $past(state_ff) == ST_PUSH,
      "result raised outside push")

endmodule

`default_nettype wire
